/* rtl/bmc_pkg.sv */
package bmc_pkg;

  localparam int unsigned MaskCols = 5;
  localparam int unsigned MaskBits = 25;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_LOADED = 2'd1,
    STAT_DONE       = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_WIDTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_ROW_RAD = 3'd2,
    CFG_COL_RAD = 3'd3,
    CFG_MASK    = 3'd4,
    CFG_FG      = 3'd5,
    CFG_BG      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic       done;
    logic [7:0] value;
  } dil_stat_t;

endpackage

/* rtl/bmc_store.sv */
module bmc_store #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bmc_dilate.sv */
module bmc_dilate import bmc_pkg::*; #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 9,
  parameter int unsigned CW = 10,
  parameter int unsigned DR = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [CW-1:0] row_i,
  input  logic signed [CW-1:0] col_i,
  input  logic [DW-1:0]        width_i,
  input  logic [DW-1:0]        height_i,
  output logic [AW-1:0]        mem_raddr_o,
  input  logic [7:0]           mem_rdata_i,
  output dil_stat_t            stat_o
);

  localparam int unsigned Span = 2 * DR + 1;
  localparam int unsigned TW   = $clog2(Span + 1);

  logic          run_q, busy_q, a_vld_q, b_vld_q;
  logic [TW-1:0] ty_q, tx_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    best_q;

  logic [CW-1:0] rr, cc;
  logic          in_frame, last_x, last_y, done;

  assign rr = row_i + CW'(ty_q) - CW'(DR);
  assign cc = col_i + CW'(tx_q) - CW'(DR);
  assign in_frame = !rr[CW-1] && !cc[CW-1] && (rr < {1'b0, height_i}) &&
                    (cc < {1'b0, width_i});
  assign last_x = (tx_q == TW'(Span - 1));
  assign last_y = (ty_q == TW'(Span - 1));
  assign done   = busy_q && !run_q && !a_vld_q && !b_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      busy_q  <= 1'b0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      tx_q    <= '0;
      ty_q    <= '0;
    end else begin
      b_vld_q <= a_vld_q;
      if (start_i) begin
        run_q   <= 1'b1;
        busy_q  <= 1'b1;
        a_vld_q <= 1'b0;
        tx_q    <= '0;
        ty_q    <= '0;
      end else if (run_q) begin
        a_vld_q <= in_frame;
        if (last_x) begin
          tx_q <= '0;
          ty_q <= ty_q + 1'b1;
          if (last_y) begin
            run_q <= 1'b0;
          end
        end else begin
          tx_q <= tx_q + 1'b1;
        end
      end else begin
        a_vld_q <= 1'b0;
        if (done) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= AW'(rr[CW-2:0]) * AW'(width_i) + AW'(cc[CW-2:0]);
    if (start_i) begin
      best_q <= '0;
    end else if (b_vld_q && mem_rdata_i > best_q) begin
      best_q <= mem_rdata_i;
    end
  end

  assign mem_raddr_o  = addr_q;
  assign stat_o.done  = done;
  assign stat_o.value = best_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> !run_q && !a_vld_q && !b_vld_q)
    else $error("dilate done with reads in flight");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done && !start_i |=> !stat_o.done)
    else $error("dilate done held");
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q && busy_q)
    else $error("dilate did not start");

endmodule

/* rtl/binary_morph_closing_frame_core.sv */
// Binary morphological closing of one frame (5x5 max dilation, masked erosion).
// Input channel (in_valid_i/in_ready_o): kind_i 0 loads the next raster pixel
// into the frame store, kind_i 1 requests the next processed pixel. Loads
// return nothing. Each read request returns one result on the
// output channel (out_valid_o/out_ready_i) with pixel_out_o, last_pixel_o and
// status_o (1 = frame not loaded, 2 = frame already read).
// A pixel read walks row/col out of the read count with a bit-serial divider,
// then one shared dilation unit visits the 25-tap window through the single
// frame store read port for each dilated value. The center costs one pass and
// each masked erosion neighbour one more, so background pixels need only the
// center pass and foreground pixels up to one more per tap of a full 5x5
// mask. Status replies skip the divider and the dilation unit.
// in_ready_o is low while a read is in progress or its result waits, so a
// stalled receiver holds the block. Configuration (cfg_valid_i/cfg_ready_o)
// is always taken; change it only while the block is idle.
// Reset clears counts and sets registers to their defaults; the frame store
// is not cleared and needs no clearing pass.
module binary_morph_closing_frame_core import bmc_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = 256,
  parameter int unsigned MAX_HEIGHT    = 256,
  parameter int unsigned DILATE_RADIUS = 2,
  parameter int unsigned MAX_KERNEL    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  pixel_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_out_o,
  output logic        last_pixel_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  localparam int unsigned MaxDim  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DW      = $clog2(MaxDim + 1);
  localparam int unsigned CW      = DW + 1;
  localparam int unsigned AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned CNTW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned DCW     = $clog2(CNTW + 1);
  localparam int unsigned MaxRad  = (MAX_KERNEL - 1) / 2;
  localparam int unsigned KW      = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_CENTER, S_CWAIT, S_NEIGH, S_NWAIT
  } state_e;

  state_e state_q;

  logic [8:0]      cfg_w_q, cfg_h_q;
  logic [1:0]      cfg_rr_q, cfg_cr_q;
  logic [24:0]     cfg_mask_q;
  logic [7:0]      cfg_fg_q, cfg_bg_q;

  logic [CNTW-1:0] load_cnt_q, read_cnt_q;
  logic [DCW-1:0]  div_cnt_q;
  logic [CNTW-1:0] quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   row_q, col_q;
  logic [7:0]      center_q;
  logic [KW-1:0]   kx_q, ky_q;

  logic            out_valid_q, last_q;
  logic [7:0]      pix_q;
  status_e         status_q;

  logic [DW-1:0]   w_eff, h_eff;
  logic [2*DW-1:0] prod;
  logic [CNTW-1:0] total;
  logic [1:0]      rr_eff, cr_eff;
  logic            in_acc, frame_clr, wr_en;
  logic [CNTW-1:0] load_base;
  logic [DW:0]     div_t;
  logic            div_ge;
  logic            interior, last_tap, tap_sel;
  logic [5:0]      tap_bit;

  logic            dil_start, dil_ctr;
  logic [CW-1:0]   dil_row, dil_col;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rdata;
  dil_stat_t       dil_stat;

  always_comb begin
    int unsigned wv, hv;
    wv = 32'(cfg_w_q);
    hv = 32'(cfg_h_q);
    w_eff = DW'((wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv));
    h_eff = DW'((hv == 0) ? 1 : ((hv > MAX_HEIGHT) ? MAX_HEIGHT : hv));
  end

  assign prod   = w_eff * h_eff;
  assign total  = prod[CNTW-1:0];
  assign rr_eff = (32'(cfg_rr_q) > MaxRad) ? 2'(MaxRad) : cfg_rr_q;
  assign cr_eff = (32'(cfg_cr_q) > MaxRad) ? 2'(MaxRad) : cfg_cr_q;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign frame_clr  = (load_cnt_q >= total) && (read_cnt_q >= total);
  assign load_base  = frame_clr ? '0 : load_cnt_q;
  assign wr_en      = in_acc && (kind_i == KIND_LOAD) && (load_base < total);

  assign div_t  = {rem_q, quo_q[CNTW-1]};
  assign div_ge = div_t >= {1'b0, w_eff};

  assign interior = ({1'b0, row_q} >= CW'(rr_eff)) &&
                    ({1'b0, row_q} + CW'(rr_eff) < {1'b0, h_eff}) &&
                    ({1'b0, col_q} >= CW'(cr_eff)) &&
                    ({1'b0, col_q} + CW'(cr_eff) < {1'b0, w_eff});

  assign tap_bit  = 6'(kx_q) * 6'(MaskCols) + 6'(ky_q);
  assign tap_sel  = (tap_bit < 6'(MaskBits)) && cfg_mask_q[tap_bit[4:0]];
  assign last_tap = (ky_q == {cr_eff, 1'b0}) && (kx_q == {rr_eff, 1'b0});

  assign dil_start = (state_q == S_CENTER) || ((state_q == S_NEIGH) && tap_sel);
  assign dil_ctr   = (state_q == S_CENTER) || (state_q == S_CWAIT);
  assign dil_row   = dil_ctr ? {1'b0, row_q} :
                     {1'b0, row_q} + CW'(kx_q) - CW'(rr_eff);
  assign dil_col   = dil_ctr ? {1'b0, col_q} :
                     {1'b0, col_q} + CW'(ky_q) - CW'(cr_eff);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 9'd256;
      cfg_h_q    <= 9'd256;
      cfg_rr_q   <= 2'd1;
      cfg_cr_q   <= 2'd1;
      cfg_mask_q <= 25'h1FFFFFF;
      cfg_fg_q   <= 8'd255;
      cfg_bg_q   <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH:   cfg_w_q    <= cfg_data_i[8:0];
        CFG_HEIGHT:  cfg_h_q    <= cfg_data_i[8:0];
        CFG_ROW_RAD: cfg_rr_q   <= cfg_data_i[1:0];
        CFG_COL_RAD: cfg_cr_q   <= cfg_data_i[1:0];
        CFG_MASK:    cfg_mask_q <= cfg_data_i;
        CFG_FG:      cfg_fg_q   <= cfg_data_i[7:0];
        CFG_BG:      cfg_bg_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_cnt_q  <= '0;
      read_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      pix_q       <= '0;
      status_q    <= STAT_OK;
      div_cnt_q   <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      center_q    <= '0;
      kx_q        <= '0;
      ky_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && kind_i == KIND_LOAD) begin
            if (frame_clr) begin
              read_cnt_q <= '0;
            end
            load_cnt_q <= wr_en ? load_base + 1'b1 : load_base;
          end else if (in_acc) begin
            if (read_cnt_q >= total) begin
              out_valid_q <= 1'b1;
              status_q    <= STAT_DONE;
              pix_q       <= '0;
              last_q      <= 1'b0;
            end else if (load_cnt_q < total) begin
              out_valid_q <= 1'b1;
              status_q    <= STAT_NOT_LOADED;
              pix_q       <= '0;
              last_q      <= 1'b0;
            end else begin
              quo_q     <= read_cnt_q;
              rem_q     <= '0;
              div_cnt_q <= DCW'(CNTW);
              state_q   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q     <= div_ge ? DW'(div_t - {1'b0, w_eff}) : div_t[DW-1:0];
          quo_q     <= {quo_q[CNTW-2:0], div_ge};
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == DCW'(1)) begin
            state_q <= S_CENTER;
          end
        end
        S_CENTER: begin
          row_q   <= quo_q[DW-1:0];
          col_q   <= rem_q;
          state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (dil_stat.done) begin
            center_q <= dil_stat.value;
            kx_q     <= '0;
            ky_q     <= '0;
            if (interior && dil_stat.value == cfg_fg_q) begin
              state_q <= S_NEIGH;
            end else begin
              out_valid_q <= 1'b1;
              status_q    <= STAT_OK;
              pix_q       <= dil_stat.value;
              last_q      <= (read_cnt_q + 1'b1 == total);
              read_cnt_q  <= read_cnt_q + 1'b1;
              state_q     <= S_IDLE;
            end
          end
        end
        S_NEIGH, S_NWAIT: begin
          if ((state_q == S_NEIGH) && tap_sel) begin
            state_q <= S_NWAIT;
          end else if ((state_q == S_NWAIT) && !dil_stat.done) begin
            state_q <= S_NWAIT;
          end else if ((state_q == S_NWAIT) && dil_stat.value == cfg_bg_q) begin
            out_valid_q <= 1'b1;
            status_q    <= STAT_OK;
            pix_q       <= cfg_bg_q;
            last_q      <= (read_cnt_q + 1'b1 == total);
            read_cnt_q  <= read_cnt_q + 1'b1;
            state_q     <= S_IDLE;
          end else if (last_tap) begin
            out_valid_q <= 1'b1;
            status_q    <= STAT_OK;
            pix_q       <= center_q;
            last_q      <= (read_cnt_q + 1'b1 == total);
            read_cnt_q  <= read_cnt_q + 1'b1;
            state_q     <= S_IDLE;
          end else begin
            if (ky_q == {cr_eff, 1'b0}) begin
              ky_q <= '0;
              kx_q <= kx_q + 1'b1;
            end else begin
              ky_q <= ky_q + 1'b1;
            end
            state_q <= S_NEIGH;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bmc_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (load_base[AW-1:0]),
    .wdata_i (pixel_in_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bmc_dilate #(
    .AW (AW),
    .DW (DW),
    .CW (CW),
    .DR (DILATE_RADIUS)
  ) u_dilate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (dil_start),
    .row_i       (dil_row),
    .col_i       (dil_col),
    .width_i     (w_eff),
    .height_i    (h_eff),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .stat_o      (dil_stat)
  );

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pix_q;
  assign last_pixel_o = last_q;
  assign status_o     = status_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o)
    else $error("input taken while a read is in progress");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> pixel_out_o == 8'd0 && !last_pixel_o)
    else $error("status reply carries pixel data");
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK && !$past(out_valid_o) |->
    read_cnt_q == $past(read_cnt_q) + 1'b1)
    else $error("read count not advanced with result");

endmodule
